@@ design/cdss_pkg.sv @@
// ----------------------------------------------------------------------------
// cdss_pkg
// Shared types, frame codes and constants for the clock display scan
// sequencer.
// ----------------------------------------------------------------------------
package cdss_pkg;

  localparam int VAL_W   = 7;
  localparam int SEG_W   = 8;
  localparam int DIGITS  = 8;
  localparam int FRAMES  = 12;
  localparam int FIDX_W  = 4;
  localparam int QDEPTH  = 2;
  localparam int QAW     = 1;
  localparam int QCNT_W  = 2;

  localparam logic [FIDX_W-1:0] FR_AMPM  = 4'd8;
  localparam logic [FIDX_W-1:0] FR_COL_A = 4'd9;
  localparam logic [FIDX_W-1:0] FR_COL_B = 4'd10;
  localparam logic [FIDX_W-1:0] FR_BLANK = 4'd11;

  localparam logic [1:0] ADJ_HOURS   = 2'd1;
  localparam logic [1:0] ADJ_MINUTES = 2'd2;

  localparam logic [15:0] SEG_AM      = 16'h0040;
  localparam logic [15:0] SEG_PM      = 16'h0080;
  localparam logic [15:0] DIG_AMPM    = 16'h8000;
  localparam logic [15:0] COLON_DIG_A = 16'h0800;
  localparam logic [15:0] COLON_DIG_B = 16'h0200;
  localparam logic [15:0] COLON_SEG   = 16'h8000;
  localparam logic [15:0] DIG_FIRST   = 16'h0100;

  typedef struct packed {
    logic [DIGITS-1:0][SEG_W-1:0] seg;
    logic [FRAMES-1:0]            mask;
    logic                         pm;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h3f;
    endcase
    return s;
  endfunction

endpackage

@@ design/clock_display_scan_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// clock_display_scan_sequencer_core
// Turns each display refresh request into a run of digit-select and segment
// words for a multiplexed seven-segment clock display.
// ----------------------------------------------------------------------------
// Each request gives a run of eight to twelve words, one word per clock cycle
// while the output is not stalled; the single output register of the frame
// sequencer sets that rate. Requests are decoded on entry and wait in a
// two-entry queue, so the next request is taken while the current run is still
// being sent, and runs follow one another without a gap. When the block is
// empty, the first word of a request passes through its queue entry and then
// the output register.
module clock_display_scan_sequencer_core import cdss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [VAL_W-1:0]  temperature,
  input  logic [VAL_W-1:0]  hours,
  input  logic [VAL_W-1:0]  minutes,
  input  logic [VAL_W-1:0]  seconds,
  input  logic [1:0]        adjust_mode,
  input  logic              blink_on,
  input  logic              pm_flag,
  input  logic              colon_on,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       digit_select,
  output logic [15:0]       segments,
  output logic              last_frame
);

  desc_t   desc;
  desc_t   head;
  q_stat_t stat;
  logic    push;
  logic    pop;

  assign in_stall = stat.full;
  assign push     = in_valid && !stat.full;

  cdss_front u_front (
    .temperature (temperature),
    .hours       (hours),
    .minutes     (minutes),
    .seconds     (seconds),
    .adjust_mode (adjust_mode),
    .blink_on    (blink_on),
    .pm_flag     (pm_flag),
    .colon_on    (colon_on),
    .desc        (desc)
  );

  cdss_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (desc),
    .pop     (pop),
    .rd_data (head),
    .stat    (stat)
  );

  cdss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .stat         (stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digit_select (digit_select),
    .segments     (segments),
    .last_frame   (last_frame)
  );

  // The closing word of a run is blank.
  a_blank_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_frame |-> digit_select == '0 && segments == '0)
    else $error("last word of a run is not blank");

  // Every other word enables exactly one digit.
  a_onehot_select: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_frame |-> $onehot(digit_select))
    else $error("digit select is not one-hot");

  // Every other word lights at least one segment.
  a_lit_segments: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_frame |-> segments != '0)
    else $error("non-final word has no segments lit");

endmodule

@@ design/cdss_front.sv @@
// ----------------------------------------------------------------------------
// cdss_front
// Saturates and splits each value, decodes the digits and works out which
// frames of the run are shown.
// ----------------------------------------------------------------------------
module cdss_front import cdss_pkg::*; (
  input  logic [VAL_W-1:0] temperature,
  input  logic [VAL_W-1:0] hours,
  input  logic [VAL_W-1:0] minutes,
  input  logic [VAL_W-1:0] seconds,
  input  logic [1:0]       adjust_mode,
  input  logic             blink_on,
  input  logic             pm_flag,
  input  logic             colon_on,
  output desc_t            desc
);

  logic [3:0][VAL_W-1:0] vals;
  logic [3:0][VAL_W-1:0] sat;
  logic [3:0][3:0]       tens;
  logic [3:0][3:0]       units;
  logic [VAL_W-1:0]      rem;

  assign vals = {temperature, seconds, minutes, hours};

  always_comb begin
    rem = '0;
    for (int i = 0; i < 4; i++) begin
      sat[i] = (vals[i] > 7'd99) ? 7'd99 : vals[i];
      tens[i] = '0;
      for (int k = 1; k < 10; k++) begin
        if (sat[i] >= VAL_W'(10 * k)) begin
          tens[i] = 4'(k);
        end
      end
      rem = sat[i] - VAL_W'({tens[i], 3'b000} + {2'b00, tens[i], 1'b0});
      units[i] = rem[3:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      desc.seg[2*i]   = seg_decode(tens[i]);
      desc.seg[2*i+1] = seg_decode(units[i]);
    end
    desc.mask = '1;
    desc.mask[FR_COL_A] = colon_on;
    desc.mask[FR_COL_B] = colon_on;
    if (adjust_mode == ADJ_HOURS && !blink_on) begin
      desc.mask[1:0] = 2'b00;
    end else if (adjust_mode == ADJ_MINUTES && !blink_on) begin
      desc.mask[3:2] = 2'b00;
    end
    desc.pm = pm_flag;
  end

endmodule

@@ design/cdss_queue.sv @@
// ----------------------------------------------------------------------------
// cdss_queue
// Two-entry queue of decoded requests between the front and the back.
// ----------------------------------------------------------------------------
module cdss_queue import cdss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  desc_t   wr_data,
  input  logic    pop,
  output desc_t   rd_data,
  output q_stat_t stat
);

  desc_t             mem [QDEPTH];
  logic [QAW-1:0]    wr_ptr;
  logic [QAW-1:0]    rd_ptr;
  logic [QCNT_W-1:0] count;

  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

@@ design/cdss_back.sv @@
// ----------------------------------------------------------------------------
// cdss_back
// Steps through the shown frames of the request at the head of the queue,
// one frame per cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module cdss_back import cdss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  desc_t       head,
  input  q_stat_t     stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] digit_select,
  output logic [15:0] segments,
  output logic        last_frame
);

  logic [FIDX_W-1:0] pos;
  logic [FRAMES-1:0] cand;
  logic [FIDX_W-1:0] idx;
  logic              fire;
  logic [15:0]       dsel_next;
  logic [15:0]       seg_next;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      cand[i] = head.mask[i] && (FIDX_W'(i) >= pos);
    end
    idx = FR_BLANK;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx = FIDX_W'(i);
      end
    end
  end

  always_comb begin
    dsel_next = '0;
    seg_next  = '0;
    case (idx)
      FR_AMPM: begin
        dsel_next = DIG_AMPM;
        seg_next  = head.pm ? SEG_PM : SEG_AM;
      end
      FR_COL_A: begin
        dsel_next = COLON_DIG_A;
        seg_next  = COLON_SEG;
      end
      FR_COL_B: begin
        dsel_next = COLON_DIG_B;
        seg_next  = COLON_SEG;
      end
      FR_BLANK: begin
        dsel_next = '0;
        seg_next  = '0;
      end
      default: begin
        dsel_next = DIG_FIRST << idx[2:0];
        seg_next  = {head.seg[idx[2:0]], 8'h00};
      end
    endcase
  end

  assign fire = !stat.empty && (!out_valid || !out_stall);
  assign pop  = fire && (idx == FR_BLANK);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        pos       <= (idx == FR_BLANK) ? '0 : idx + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      digit_select <= dsel_next;
      segments     <= seg_next;
      last_frame   <= (idx == FR_BLANK);
    end
  end

endmodule

@@ tb/clock_display_scan_sequencer_core_test.sv @@
// ----------------------------------------------------------------------------
// clock_display_scan_sequencer_core_test
// Self-checking bench for the clock display scan sequencer. Refresh requests
// from a queue are offered by a clocked driver. Every accepted request is
// expanded into its expected run of frame words. A clocked monitor compares
// each accepted frame word with the oldest expected one, while both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module clock_display_scan_sequencer_core_test;
  import cdss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [VAL_W-1:0] temperature;
    logic [VAL_W-1:0] hours;
    logic [VAL_W-1:0] minutes;
    logic [VAL_W-1:0] seconds;
    logic [1:0]       adjust_mode;
    logic             blink_on;
    logic             pm_flag;
    logic             colon_on;
  } refresh_t;

  typedef struct {
    logic [15:0] digit_select;
    logic [15:0] segments;
    logic        last_frame;
  } frame_t;

  localparam logic [9:0][7:0] GLYPHS = {8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d,
                                        8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int STALL_LIMIT     = 2000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [VAL_W-1:0] temperature = '0;
  logic [VAL_W-1:0] hours = '0;
  logic [VAL_W-1:0] minutes = '0;
  logic [VAL_W-1:0] seconds = '0;
  logic [1:0]       adjust_mode = '0;
  logic             blink_on = 1'b0;
  logic             pm_flag = 1'b0;
  logic             colon_on = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [15:0]      digit_select;
  logic [15:0]      segments;
  logic             last_frame;

  refresh_t pending_requests[$];
  frame_t   expected_frames[$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_off_asked = 0;
  int       hold_off_served = 0;
  int       hold_off_left = 0;
  int       mismatches = 0;
  int       requests_taken = 0;
  int       frames_checked = 0;
  int       hidden_runs = 0;
  int       colon_runs = 0;
  int       quiet_cycles = 0;

  clock_display_scan_sequencer_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .temperature(temperature), .hours(hours), .minutes(minutes), .seconds(seconds),
    .adjust_mode(adjust_mode), .blink_on(blink_on), .pm_flag(pm_flag),
    .colon_on(colon_on),
    .out_valid(out_valid), .out_stall(out_stall),
    .digit_select(digit_select), .segments(segments), .last_frame(last_frame)
  );

  always #6 clk = ~clk;

  function automatic logic [VAL_W-1:0] clamp_to_99(input logic [VAL_W-1:0] v);
    return (v > 7'd99) ? 7'd99 : v;
  endfunction

  task automatic queue_expected_run(input refresh_t r);
    logic [VAL_W-1:0] vals [4];
    logic [3:0]       d;
    frame_t           f;
    bit               shown;
    vals[0] = clamp_to_99(r.hours);
    vals[1] = clamp_to_99(r.minutes);
    vals[2] = clamp_to_99(r.seconds);
    vals[3] = clamp_to_99(r.temperature);
    for (int i = 0; i < DIGITS; i++) begin
      d = (i % 2 == 0) ? 4'(vals[i / 2] / 10) : 4'(vals[i / 2] % 10);
      shown = 1'b1;
      if (!r.blink_on && r.adjust_mode == ADJ_HOURS && i < 2) shown = 1'b0;
      if (!r.blink_on && r.adjust_mode == ADJ_MINUTES && (i == 2 || i == 3)) shown = 1'b0;
      if (shown) begin
        f.digit_select = DIG_FIRST << i;
        f.segments = {GLYPHS[d], 8'h00};
        f.last_frame = 1'b0;
        expected_frames.push_back(f);
      end
    end
    if (!r.blink_on && (r.adjust_mode == ADJ_HOURS || r.adjust_mode == ADJ_MINUTES)) begin
      hidden_runs++;
    end
    f.digit_select = DIG_AMPM;
    f.segments = r.pm_flag ? SEG_PM : SEG_AM;
    f.last_frame = 1'b0;
    expected_frames.push_back(f);
    if (r.colon_on) begin
      colon_runs++;
      f.digit_select = COLON_DIG_A;
      f.segments = COLON_SEG;
      expected_frames.push_back(f);
      f.digit_select = COLON_DIG_B;
      expected_frames.push_back(f);
    end
    f.digit_select = '0;
    f.segments = '0;
    f.last_frame = 1'b1;
    expected_frames.push_back(f);
  endtask

  task automatic add_request(input int t, input int h, input int m, input int s,
                             input int mode, input int blink, input int pm,
                             input int colon);
    refresh_t r;
    r.temperature = VAL_W'(t);
    r.hours = VAL_W'(h);
    r.minutes = VAL_W'(m);
    r.seconds = VAL_W'(s);
    r.adjust_mode = 2'(mode);
    r.blink_on = 1'(blink);
    r.pm_flag = 1'(pm);
    r.colon_on = 1'(colon);
    pending_requests.push_back(r);
  endtask

  function automatic int random_value();
    if ($urandom_range(9) == 0) return int'($urandom_range(127, 100));
    return int'($urandom_range(99));
  endfunction

  task automatic add_random_requests(input int count);
    for (int n = 0; n < count; n++) begin
      add_request(random_value(), random_value(), random_value(), random_value(),
                  int'($urandom_range(3)), int'($urandom_range(1)),
                  int'($urandom_range(1)), int'($urandom_range(1)));
    end
  endtask

  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || in_valid || expected_frames.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_requests
    refresh_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        nxt.temperature = temperature;
        nxt.hours = hours;
        nxt.minutes = minutes;
        nxt.seconds = seconds;
        nxt.adjust_mode = adjust_mode;
        nxt.blink_on = blink_on;
        nxt.pm_flag = pm_flag;
        nxt.colon_on = colon_on;
        queue_expected_run(nxt);
        requests_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_requests.pop_front();
          in_valid <= 1'b1;
          temperature <= nxt.temperature;
          hours <= nxt.hours;
          minutes <= nxt.minutes;
          seconds <= nxt.seconds;
          adjust_mode <= nxt.adjust_mode;
          blink_on <= nxt.blink_on;
          pm_flag <= nxt.pm_flag;
          colon_on <= nxt.colon_on;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_off_left <= 0;
    end else if (hold_off_left != 0) begin
      out_stall <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_served != hold_off_asked) begin
      out_stall <= 1'b1;
      hold_off_left <= HOLD_OFF_CYCLES;
      hold_off_served <= hold_off_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_frames
    frame_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected word: dsel %h seg %h last %b",
                   digit_select, segments, last_frame);
        end
      end else begin
        want = expected_frames.pop_front();
        frames_checked++;
        if (want.digit_select !== digit_select || want.segments !== segments ||
            want.last_frame !== last_frame) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Word %0d: expected dsel %h seg %h last %b, got dsel %h seg %h last %b",
                     frames_checked, want.digit_select, want.segments, want.last_frame,
                     digit_select, segments, last_frame);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a word moving.", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    send_idle_pct = 24;
    recv_idle_pct = 54;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_request(0, 0, 0, 0, 0, 0, 0, 0);
    add_request(99, 99, 99, 99, 0, 1, 1, 1);
    add_request(127, 127, 127, 127, 3, 0, 0, 1);
    add_request(100, 100, 100, 100, 0, 0, 1, 0);
    add_request(78, 12, 34, 56, 0, 1, 0, 1);
    add_request(90, 9, 90, 9, 0, 0, 1, 1);
    add_request(85, 42, 85, 42, 0, 0, 0, 0);
    add_request(42, 85, 42, 85, 3, 1, 1, 0);
    add_request(21, 11, 45, 30, 1, 0, 0, 1);
    add_request(21, 11, 45, 30, 1, 1, 1, 1);
    add_request(67, 7, 59, 3, 2, 0, 1, 0);
    add_request(67, 7, 59, 3, 2, 1, 0, 0);
    add_request(33, 23, 0, 59, 3, 0, 1, 1);
    add_request(127, 0, 127, 0, 1, 0, 1, 0);
    add_request(0, 127, 0, 127, 2, 0, 0, 1);
    add_request(64, 1, 2, 104, 0, 1, 1, 0);
    wait_until_drained();

    // The receiver holds off while requests keep coming, filling the block.
    add_random_requests(20);
    hold_off_asked = hold_off_asked + 1;
    add_random_requests(50);
    wait_until_drained();

    send_idle_pct = 54;
    recv_idle_pct = 24;
    add_random_requests(75);
    wait_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_requests(75);
    wait_until_drained();
    repeat (10) @(posedge clk);

    $display("Run covered %0d refresh requests and %0d frame words, %0d with a hidden field",
             requests_taken, frames_checked, hidden_runs);
    $display("and %0d with colon dots, under random and long stalls on both sides.",
             colon_runs);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatching words, %0d words never seen.",
               mismatches, expected_frames.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/cdss_pkg.sv
design/cdss_front.sv
design/cdss_queue.sv
design/cdss_back.sv
design/clock_display_scan_sequencer_core.sv
tb/clock_display_scan_sequencer_core_test.sv
